/* hdl/pvob_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvob_pkg
// Shared types and constants for the pv operating point bisection block.
// ----------------------------------------------------------------------------
package pvob_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CURR_DIV  = 1000;
  localparam int unsigned PROD_W    = 44;
  localparam int unsigned A_W       = 34;
  localparam int unsigned ADIV_CNT_W = 2;
  localparam int unsigned ADIV_DIG_W = 11;
  localparam int unsigned ADIV_REM_W = 10;
  localparam int unsigned ADIV_STEPS = PROD_W / ADIV_DIG_W;
  localparam int unsigned ADIV_RECIP = 2147484;
  localparam int unsigned ADIV_RECIP_W = 22;
  localparam int unsigned ADIV_SHIFT = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOC         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ISC         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IRRADIANCE  = 3'd6;

  typedef struct packed {
    logic start_item;
    logic eval_start;
    logic eval_sel_lo;
    logic take_lo_sign;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic a_busy;
    logic ev_done;
    logic step_conv;
    logic step_limit;
  } stat_t;

endpackage

/* hdl/pvob_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvob_datapath
// Bisection registers, serial panel current evaluator and residual sign.
// ----------------------------------------------------------------------------
module pvob_datapath #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  pvob_pkg::cmd_t      cmd,
  output pvob_pkg::stat_t     stat,
  input  logic [31:0]         load_resistance,
  input  logic [31:0]         search_low,
  input  logic [31:0]         search_high,
  input  logic [31:0]         tolerance,
  input  logic [7:0]          iteration_limit,
  input  logic [31:0]         open_circuit_voltage,
  input  logic [31:0]         short_circuit_current,
  input  logic [10:0]         irradiance,
  output logic [31:0]         res_voltage,
  output logic [31:0]         res_current,
  output logic                res_converged,
  output logic [7:0]          res_iterations
);
  import pvob_pkg::*;

  localparam int unsigned ACC_W = A_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 3);
  localparam int unsigned AT_W  = ADIV_REM_W + ADIV_DIG_W;
  localparam int unsigned AM_W  = AT_W + ADIV_RECIP_W;

  logic [31:0]         r_load;
  logic [31:0]         lo;
  logic [31:0]         hi;
  logic [31:0]         x;
  logic [7:0]          n;
  logic                sl_pos;
  logic                sl_neg;
  logic                conv;

  logic [PROD_W-1:0]   adq;
  logic [ADIV_REM_W-1:0] arem;
  logic [ADIV_CNT_W-1:0] acnt;
  logic                a_busy;
  logic [AT_W-1:0]     at;
  logic [AM_W-1:0]     at_mul;
  logic [ADIV_DIG_W-1:0] aq;
  logic [AT_W-1:0]     aq_prod;
  logic [AT_W-1:0]     arem_full;

  logic [31:0]         ev_v;
  logic                ev_zero;
  logic [32:0]         den;
  logic [33:0]         rem;
  logic [ACC_W-1:0]    acc;
  logic [CNT_W-1:0]    ev_cnt;
  logic                ev_busy;
  logic                ev_done;
  logic                ev_pos;
  logic                ev_neg;
  logic [31:0]         cur;
  logic [63:0]         lhs;

  logic [31:0]         v_sel;
  logic [31:0]         d_sel;
  logic [33:0]         rem_sh;
  logic                dge;
  logic [A_W-1:0]      i_raw;
  logic [63:0]         rhs;

  logic                opp;
  logic [31:0]         lo_next;
  logic [31:0]         hi_next;
  logic [32:0]         mid_sum;
  logic [31:0]         x1;
  logic [31:0]         diff;
  logic [7:0]          n_next;
  logic                conv_next;

  assign v_sel  = cmd.eval_sel_lo ? lo : x;
  assign d_sel  = open_circuit_voltage - v_sel;
  assign rem_sh = {rem[32:0], 1'b0};
  assign dge    = rem_sh >= {1'b0, den};
  assign i_raw  = acc[ACC_W-1:FRAC_BITS];
  assign rhs    = {16'b0, ev_v, 16'b0};

  // one quotient digit per cycle by reciprocal multiplication
  assign at        = {arem, adq[PROD_W-1 -: ADIV_DIG_W]};
  assign at_mul    = AM_W'(at) * AM_W'(ADIV_RECIP);
  assign aq        = at_mul[ADIV_SHIFT +: ADIV_DIG_W];
  assign aq_prod   = AT_W'(aq) * AT_W'(CURR_DIV);
  assign arem_full = at - aq_prod;

  assign opp       = (sl_pos && ev_neg) || (sl_neg && ev_pos);
  assign lo_next   = opp ? lo : x;
  assign hi_next   = opp ? x : hi;
  assign mid_sum   = {1'b0, lo_next} + {1'b0, hi_next};
  assign x1        = mid_sum[32:1];
  assign diff      = (x1 > x) ? (x1 - x) : (x - x1);
  assign conv_next = diff < tolerance;
  assign n_next    = n + 8'd1;

  assign stat.a_busy     = a_busy;
  assign stat.ev_done    = ev_done;
  assign stat.step_conv  = conv_next;
  assign stat.step_limit = n_next >= iteration_limit;

  assign res_voltage    = x;
  assign res_current    = cur;
  assign res_converged  = conv;
  assign res_iterations = n;

  // item setup, bisection step and the constant a = isc * g / 1000
  always_ff @(posedge clk) begin
    if (rst) begin
      a_busy <= 1'b0;
    end else begin
      if (cmd.start_item) begin
        r_load <= load_resistance;
        lo     <= search_low;
        hi     <= search_high;
        x      <= 32'(({1'b0, search_low} + {1'b0, search_high}) >> 1);
        n      <= 8'd1;
        adq    <= {12'b0, short_circuit_current} * {33'b0, irradiance};
        arem   <= '0;
        acnt   <= '0;
        a_busy <= 1'b1;
      end else if (a_busy) begin
        arem <= arem_full[ADIV_REM_W-1:0];
        adq  <= {adq[PROD_W-ADIV_DIG_W-1:0], aq};
        acnt <= acnt + 1'b1;
        if (acnt == ADIV_CNT_W'(ADIV_STEPS - 1)) begin
          a_busy <= 1'b0;
        end
      end
      if (cmd.take_lo_sign) begin
        sl_pos <= ev_pos;
        sl_neg <= ev_neg;
      end
      if (cmd.step) begin
        lo   <= lo_next;
        hi   <= hi_next;
        n    <= n_next;
        conv <= conv_next;
        if (!opp) begin
          sl_pos <= ev_pos;
          sl_neg <= ev_neg;
        end
        if (!conv_next) begin
          x <= x1;
        end
      end
    end
  end

  // serial current evaluation: restoring divide with shift-add multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_busy <= 1'b0;
      ev_done <= 1'b0;
    end else begin
      ev_done <= 1'b0;
      if (cmd.eval_start) begin
        ev_v    <= v_sel;
        ev_zero <= v_sel >= open_circuit_voltage;
        den     <= {1'b0, d_sel} + (33'd1 << FRAC_BITS);
        rem     <= {2'b0, d_sel};
        acc     <= '0;
        ev_cnt  <= '0;
        ev_busy <= 1'b1;
      end else if (ev_busy) begin
        ev_cnt <= ev_cnt + 1'b1;
        if (ev_cnt < CNT_W'(FRAC_BITS)) begin
          rem <= dge ? (rem_sh - {1'b0, den}) : rem_sh;
          acc <= {acc[ACC_W-2:0], 1'b0} +
                 (dge ? {{FRAC_BITS{1'b0}}, adq[A_W-1:0]} : {ACC_W{1'b0}});
        end else if (ev_cnt == CNT_W'(FRAC_BITS)) begin
          if (ev_zero) begin
            cur <= '0;
          end else if (i_raw[A_W-1:32] != '0) begin
            cur <= '1;
          end else begin
            cur <= i_raw[31:0];
          end
        end else if (ev_cnt == CNT_W'(FRAC_BITS + 1)) begin
          lhs <= {32'b0, cur} * {32'b0, r_load};
        end else begin
          ev_pos  <= lhs > rhs;
          ev_neg  <= lhs < rhs;
          ev_busy <= 1'b0;
          ev_done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/pvob_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvob_ctrl
// Sequencer for the bisection search and result hand-off.
// ----------------------------------------------------------------------------
module pvob_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  pvob_pkg::stat_t stat,
  output pvob_pkg::cmd_t  cmd
);
  import pvob_pkg::*;

  typedef enum logic [2:0] {
    IDLE, PREP, LO_WAIT, X_WAIT, X_ISSUE, FIN_ISSUE, FIN_WAIT, RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start_item = 1'b1;
          state_next     = PREP;
        end
      end
      PREP: begin
        if (!stat.a_busy) begin
          cmd.eval_start  = 1'b1;
          cmd.eval_sel_lo = 1'b1;
          state_next      = LO_WAIT;
        end
      end
      LO_WAIT: begin
        if (stat.ev_done) begin
          cmd.take_lo_sign = 1'b1;
          cmd.eval_start   = 1'b1;
          state_next       = X_WAIT;
        end
      end
      X_WAIT: begin
        if (stat.ev_done) begin
          cmd.step   = 1'b1;
          state_next = (stat.step_conv || stat.step_limit) ? FIN_ISSUE : X_ISSUE;
        end
      end
      X_ISSUE: begin
        cmd.eval_start = 1'b1;
        state_next     = X_WAIT;
      end
      FIN_ISSUE: begin
        cmd.eval_start = 1'b1;
        state_next     = FIN_WAIT;
      end
      FIN_WAIT: begin
        if (stat.ev_done) begin
          state_next = RESULT;
        end
      end
      RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/pv_operating_point_bisection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pv_operating_point_bisection
// Solves the panel voltage at which panel current times load equals voltage.
// ----------------------------------------------------------------------------
// Usage: a load resistance enters on the in channel (in_valid/in_ready); one
// result (voltage, current, converged flag, iteration count) leaves on the
// out channel (out_valid/out_ready). Configuration registers are written on
// the cfg channel (cfg_index/cfg_data), always ready; the user must write
// them only while idle, as the block does not enforce this. The current
// evaluator is serial: one divide and one multiply-add step per cycle,
// FRAC_BITS steps followed by saturation, multiply and compare per
// evaluation, iterations + 1 evaluations per item, after a four-step
// scaling of the short-circuit current by irradiance. One item is in work
// at a time; the next item is taken in the cycle after the result is loaded.
// A new item is taken as soon as the previous result sits in the output
// register, even while the receiver stalls; a result waits there until
// transferred, and the search holds until the register is free. Reset
// restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module pv_operating_point_bisection #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     load_resistance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     panel_voltage,
  output logic [31:0]                     panel_current,
  output logic                            converged,
  output logic [7:0]                      iterations,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pvob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import pvob_pkg::*;

  logic [31:0] search_low;
  logic [31:0] search_high;
  logic [31:0] tolerance;
  logic [7:0]  iteration_limit;
  logic [31:0] open_circuit_voltage;
  logic [31:0] short_circuit_current;
  logic [10:0] irradiance;

  cmd_t        cmd;
  stat_t       stat;
  logic        out_free;
  logic [31:0] res_voltage;
  logic [31:0] res_current;
  logic        res_converged;
  logic [7:0]  res_iterations;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_low            <= 32'd0;
      search_high           <= 32'd1048576000;
      tolerance             <= 32'd1;
      iteration_limit       <= 8'd100;
      open_circuit_voltage  <= 32'd41943040;
      short_circuit_current <= 32'd8388608;
      irradiance            <= 11'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEARCH_LOW:  search_low            <= cfg_data;
        REG_SEARCH_HIGH: search_high           <= cfg_data;
        REG_TOLERANCE:   tolerance             <= cfg_data;
        REG_ITER_LIMIT:  iteration_limit       <= cfg_data[7:0];
        REG_VOC:         open_circuit_voltage  <= cfg_data;
        REG_ISC:         short_circuit_current <= cfg_data;
        REG_IRRADIANCE:  irradiance            <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid     <= 1'b1;
        panel_voltage <= res_voltage;
        panel_current <= res_current;
        converged     <= res_converged;
        iterations    <= res_iterations;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  pvob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  pvob_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .load_resistance       (load_resistance),
    .search_low            (search_low),
    .search_high           (search_high),
    .tolerance             (tolerance),
    .iteration_limit       (iteration_limit),
    .open_circuit_voltage  (open_circuit_voltage),
    .short_circuit_current (short_circuit_current),
    .irradiance            (irradiance),
    .res_voltage           (res_voltage),
    .res_current           (res_current),
    .res_converged         (res_converged),
    .res_iterations        (res_iterations)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pv operating point bisection block against its own predictor of
// the bisection search: each accepted load resistance is solved here and the
// result fields are compared in order, under several register settings and
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import pvob_pkg::*;

  localparam int unsigned FB = 20;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic [31:0] voltage;
    logic [31:0] current;
    logic        conv;
    logic [7:0]  iters;
  } solution_t;

  class solution_board;
    logic [63:0] s_low, s_high, tol, limit, voc, isc, irr;
    solution_t   pending[$];
    int          mismatches;
    int          solved;

    function void reset_regs();
      s_low = 0; s_high = 64'd1048576000; tol = 1; limit = 100;
      voc = 64'd41943040; isc = 64'd8388608; irr = 1000;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_SEARCH_LOW:  s_low = 64'(data);
        REG_SEARCH_HIGH: s_high = 64'(data);
        REG_TOLERANCE:   tol = 64'(data);
        REG_ITER_LIMIT:  limit = 64'(data[7:0]);
        REG_VOC:         voc = 64'(data);
        REG_ISC:         isc = 64'(data);
        REG_IRRADIANCE:  irr = 64'(data[10:0]);
        default: ;
      endcase
    endfunction

    function logic [63:0] panel_amps(logic [63:0] v);
      logic [63:0] d, r, a, i;
      if (v >= voc) return 0;
      d = voc - v;
      r = (d << FB) / (d + (64'd1 << FB));
      a = (isc * irr) / 1000;
      i = (a * r) >> FB;
      return (i > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : i;
    endfunction

    function int residual_sign(logic [63:0] v, logic [63:0] ohms);
      logic [63:0] lhs, rhs;
      lhs = panel_amps(v) * ohms;
      rhs = v << 16;
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
    endfunction

    function void note_load(logic [31:0] ohms);
      logic [63:0] lo, hi, x, x1, delta, n;
      int sl, sx;
      bit done;
      solution_t s;
      lo = s_low; hi = s_high; done = 0;
      x = (lo + hi) >> 1;
      n = 1;
      do begin
        sl = residual_sign(lo, 64'(ohms));
        sx = residual_sign(x, 64'(ohms));
        if ((sl > 0 && sx < 0) || (sl < 0 && sx > 0)) hi = x;
        else lo = x;
        x1 = (lo + hi) >> 1;
        n++;
        delta = (x1 > x) ? x1 - x : x - x1;
        if (delta < tol) begin
          done = 1;
          break;
        end
        x = x1;
      end while (n < limit);
      s.voltage = x[31:0];
      s.current = 32'(panel_amps(x));
      s.conv = done;
      s.iters = n[7:0];
      pending.push_back(s);
    endfunction

    function void check_solution(logic [31:0] v, logic [31:0] c, logic cv, logic [7:0] it);
      solution_t e;
      solved++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result v=%h i=%h", v, c);
        return;
      end
      e = pending.pop_front();
      if (e.voltage !== v || e.current !== c || e.conv !== cv || e.iters !== it) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp v=%h i=%h conv=%b n=%0d, got v=%h i=%h conv=%b n=%0d",
                   e.voltage, e.current, e.conv, e.iters, v, c, cv, it);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [31:0] load_resistance = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] panel_voltage, panel_current;
  logic converged;
  logic [7:0] iterations;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  solution_board board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit held_once = 0;
  int quiet_cycles = 0;
  int loads_sent = 0;

  always #6 clk = ~clk;

  pv_operating_point_bisection #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .load_resistance(load_resistance),
    .out_valid(out_valid), .out_ready(out_ready),
    .panel_voltage(panel_voltage), .panel_current(panel_current),
    .converged(converged), .iterations(iterations),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // result side, with one long hold-off once the block has been busy a while
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_solution(panel_voltage, panel_current, converged, iterations);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 0;
      end else if (!held_once && board.solved == 40) begin
        held_once <= 1;
        hold_left <= 3000;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_load(logic [31:0] ohms);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    load_resistance <= ohms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_load(ohms);
    loads_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic random_regs();
    logic [31:0] a, b;
    a = $urandom_range(0, 32'd100 << FB);
    b = $urandom_range(0, 32'd1000 << FB);
    if ($urandom_range(3) == 0) begin
      a = $urandom; b = $urandom;
    end
    write_reg(REG_SEARCH_LOW, a);
    write_reg(REG_SEARCH_HIGH, b);
    case ($urandom_range(3))
      0: write_reg(REG_TOLERANCE, 0);
      1: write_reg(REG_TOLERANCE, $urandom);
      default: write_reg(REG_TOLERANCE, $urandom_range(1, 4096));
    endcase
    write_reg(REG_ITER_LIMIT, ($urandom_range(9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 40));
    write_reg(REG_VOC, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'd80 << FB));
    write_reg(REG_ISC, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'd20 << FB));
    write_reg(REG_IRRADIANCE, $urandom_range(0, 2047));
  endtask

  initial begin
    board = new();
    board.reset_regs();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default registers, load extremes
    send_load(0);
    send_load(32'hFFFF_FFFF);
    send_load(1);
    send_load(32'd5 << 16);
    send_load(32'd10 << 16);
    send_load(32'd100 << 16);
    send_load(32'h8000_0000);
    wait_idle();

    write_reg(REG_ITER_LIMIT, 1);
    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_load(32'd5 << 16);
    send_load(32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_ITER_LIMIT, 0);
    send_load(32'd3 << 16);
    wait_idle();

    write_reg(REG_SEARCH_LOW, 32'hFFFF_FFFF);
    write_reg(REG_SEARCH_HIGH, 0);
    write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
    write_reg(REG_ITER_LIMIT, 255);
    write_reg(REG_VOC, 32'hFFFF_FFFF);
    write_reg(REG_ISC, 32'hFFFF_FFFF);
    write_reg(REG_IRRADIANCE, 11'h7FF);
    send_load(32'd7 << 16);
    send_load(32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_TOLERANCE, 2048);
    send_load(32'd1 << 16);
    send_load(0);
    wait_idle();

    write_reg(REG_SEARCH_LOW, 0);
    write_reg(REG_SEARCH_HIGH, 32'hFFFF_FFFF);
    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_VOC, 0);
    write_reg(REG_ISC, 0);
    write_reg(REG_IRRADIANCE, 0);
    send_load(32'd10 << 16);
    wait_idle();
    write_reg(REG_VOC, 32'd40 << FB);
    write_reg(REG_ISC, 32'd8 << FB);
    write_reg(REG_IRRADIANCE, 1000);
    send_load(32'd4 << 16);
    send_load(32'd20 << 16);
    wait_idle();

    // random part: four idling modes, fresh registers every eleven transfers
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int k = 0; k < 22; k++) begin
        if (k % 11 == 0) begin
          wait_idle();
          random_regs();
        end
        case ($urandom_range(3))
          0: send_load($urandom);
          default: send_load($urandom_range(0, 32'd200 << 16));
        endcase
      end
    end
    wait_idle();

    $display("covered %0d loads, %0d results, register extremes and four idling modes",
             loads_sent, board.solved);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
